// ----- hdl/record_marker_strip_word_swap_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the record deframer
// Shared concurrent-assertion wrappers, clocked on clk_i with async reset.
// ----------------------------------------------------------------------------
`ifndef RECORD_MARKER_STRIP_WORD_SWAP_TOP_ASSERT_SVH
`define RECORD_MARKER_STRIP_WORD_SWAP_TOP_ASSERT_SVH

// Same-cycle implication.
`define RMSWS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmsws: assertion failed");

// Next-cycle implication.
`define RMSWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmsws: assertion failed");

`endif

// ----- hdl/rmsws_pkg.sv -----
// ----------------------------------------------------------------------------
// rmsws_pkg
// Types and constants shared by the record deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmsws_pkg;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 40;
  localparam logic [CFG_INDEX_W-1:0] CFG_REC_BYTES     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_TOTAL = 8'd1;

  // Register reset values
  localparam logic [31:0] DEFAULT_RECORD_BYTES = 32'd2147483639;
  localparam logic [39:0] DEFAULT_TOTAL        = 40'd28991029248;

  // File framing
  localparam logic [31:0] HEADER_MARKER     = 32'd40;
  localparam logic [5:0]  HEADER_BYTES      = 6'd40;
  localparam logic [5:0]  HEADER_TOTAL_BYTES = 6'd8;
  localparam logic [5:0]  MARKER_PAIR_BYTES = 6'd8;

  // Token queue depth
  localparam int unsigned TOKEN_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_HEADER,
    PH_HDR_MARK,
    PH_PAYLOAD,
    PH_REC_MARK,
    PH_DONE
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word_bits;
    logic [1:0]  component;
    logic        last_word;
  } out_item_t;

  // One payload byte, classified by the front end
  typedef struct packed {
    logic [7:0] data;
    logic       word_end;
    logic [1:0] component;
    logic       last_word;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- hdl/rmsws_if.sv -----
// ----------------------------------------------------------------------------
// rmsws channel interfaces
// Valid/ready channels for input bytes, output words and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rmsws_in_if;
  import rmsws_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rmsws_out_if;
  import rmsws_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rmsws_cfg_if;
  import rmsws_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- hdl/rmsws_fifo.sv -----
// ----------------------------------------------------------------------------
// rmsws_fifo
// Small token queue between the parser front end and the word packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmsws_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rmsws_pkg::token_t   push_data_i,
  input  logic                pop_i,
  output rmsws_pkg::token_t   pop_data_o,
  output rmsws_pkg::fifo_stat_t stat_o
);
  import rmsws_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  token_t          slot_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = slot_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

// ----- hdl/rmsws_front.sv -----
// ----------------------------------------------------------------------------
// rmsws_front
// Byte parser: lead marker, header, marker stripping and word/particle count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmsws_front #(
  parameter int unsigned RECORD_COUNT_BITS = 31,
  parameter int unsigned TOTAL_BITS        = 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rmsws_in_if.sink                     in_i,
  input  rmsws_pkg::fifo_stat_t        fifo_stat_i,
  input  logic [RECORD_COUNT_BITS-1:0] rec_bytes_i,
  input  logic [39:0]                  default_total_i,
  output logic                         tok_push_o,
  output rmsws_pkg::token_t            tok_o
);
  import rmsws_pkg::*;

  localparam int unsigned PW = TOTAL_BITS - 2;
  localparam logic [63:0] TotalMax = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TOTAL_BITS);

  parse_phase_e                 phase_q, phase_d;
  logic [5:0]                   cnt_q, cnt_d;
  logic [23:0]                  lead_q, lead_d;
  logic [63:0]                  capture_q, capture_d;
  logic [TOTAL_BITS-1:0]        hdr_total_q, hdr_total_d;
  logic [RECORD_COUNT_BITS-1:0] rec_cnt_q, rec_cnt_d;
  logic [1:0]                   wbi_q, wbi_d;
  logic [1:0]                   coord_q, coord_d;
  logic [PW-1:0]                left_q, left_d;

  logic                         fire;
  logic [7:0]                   b;
  logic [63:0]                  dflt_ext;
  logic [TOTAL_BITS-1:0]        dflt_sat;
  logic [TOTAL_BITS-1:0]        cap_sat;
  logic [5:0]                   cnt_inc;
  logic [RECORD_COUNT_BITS-1:0] rec_inc;
  logic [PW-1:0]                left_dec;
  logic [31:0]                  marker;

  assign in_i.ready = !fifo_stat_i.full;
  assign fire       = in_i.valid && in_i.ready;
  assign b          = in_i.data.in_byte;

  // Saturated totals from the register and from the header
  assign dflt_ext = {24'd0, default_total_i};
  assign dflt_sat = (dflt_ext > TotalMax) ? TotalMax[TOTAL_BITS-1:0]
                                          : dflt_ext[TOTAL_BITS-1:0];
  assign cap_sat  = capture_q[63]          ? '0 :
                    (capture_q > TotalMax) ? TotalMax[TOTAL_BITS-1:0]
                                           : capture_q[TOTAL_BITS-1:0];

  // Parse state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      cnt_q       <= '0;
      lead_q      <= '0;
      capture_q   <= '0;
      hdr_total_q <= '0;
      rec_cnt_q   <= '0;
      wbi_q       <= '0;
      coord_q     <= '0;
      left_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      lead_q      <= lead_d;
      capture_q   <= capture_d;
      hdr_total_q <= hdr_total_d;
      rec_cnt_q   <= rec_cnt_d;
      wbi_q       <= wbi_d;
      coord_q     <= coord_d;
      left_q      <= left_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    lead_d      = lead_q;
    capture_d   = capture_q;
    hdr_total_d = hdr_total_q;
    rec_cnt_d   = rec_cnt_q;
    wbi_d       = wbi_q;
    coord_d     = coord_q;
    left_d      = left_q;
    tok_push_o  = 1'b0;
    tok_o       = '{data: b, word_end: (wbi_q == 2'd3), component: coord_q,
                    last_word: 1'b0};
    cnt_inc     = 6'd0;
    rec_inc     = '0;
    left_dec    = '0;
    marker      = '0;

    if (fire) begin
      // A file start drops everything and restarts at the lead marker
      if (in_i.data.file_start) begin
        phase_d     = PH_LEAD;
        cnt_d       = '0;
        lead_d      = '0;
        capture_d   = '0;
        hdr_total_d = '0;
        rec_cnt_d   = '0;
        wbi_d       = '0;
        coord_d     = '0;
        left_d      = '0;
      end
      cnt_inc  = cnt_d + 6'd1;
      rec_inc  = rec_cnt_d + RECORD_COUNT_BITS'(1);
      left_dec = left_d - PW'(1);

      case (phase_d)
        PH_LEAD: begin
          cnt_d = cnt_inc;
          if (cnt_inc[1:0] != 2'd0) begin
            lead_d[8*cnt_inc[1:0]-8 +: 8] = b;
          end else begin
            marker = {b, lead_d};
            cnt_d  = '0;
            if (marker == HEADER_MARKER) begin
              capture_d = '0;
              phase_d   = PH_HEADER;
            end else begin
              left_d    = dflt_sat[TOTAL_BITS-1:2];
              rec_cnt_d = '0;
              wbi_d     = '0;
              coord_d   = '0;
              phase_d   = (dflt_sat[TOTAL_BITS-1:2] != '0) ? PH_PAYLOAD : PH_DONE;
            end
          end
        end
        PH_HEADER: begin
          if (cnt_d < HEADER_TOTAL_BYTES) begin
            capture_d[8*cnt_d[2:0] +: 8] = b;
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= HEADER_BYTES) begin
            hdr_total_d = cap_sat;
            cnt_d       = '0;
            phase_d     = PH_HDR_MARK;
          end
        end
        PH_HDR_MARK: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= MARKER_PAIR_BYTES) begin
            left_d    = hdr_total_q[TOTAL_BITS-1:2];
            rec_cnt_d = '0;
            cnt_d     = '0;
            wbi_d     = '0;
            coord_d   = '0;
            phase_d   = (hdr_total_q[TOTAL_BITS-1:2] != '0) ? PH_PAYLOAD : PH_DONE;
          end
        end
        PH_PAYLOAD: begin
          tok_push_o = 1'b1;
          if (wbi_d == 2'd3) begin
            wbi_d = '0;
            if (coord_d >= 2'd2) begin
              coord_d = '0;
              left_d  = left_dec;
              if (left_dec == '0) begin
                tok_o.last_word = 1'b1;
                phase_d         = PH_DONE;
              end
            end else begin
              coord_d = coord_d + 2'd1;
            end
          end else begin
            wbi_d = wbi_d + 2'd1;
          end
          rec_cnt_d = rec_inc;
          if (phase_d == PH_PAYLOAD && rec_inc == rec_bytes_i) begin
            rec_cnt_d = '0;
            cnt_d     = '0;
            phase_d   = PH_REC_MARK;
          end
        end
        PH_REC_MARK: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= MARKER_PAIR_BYTES) begin
            cnt_d   = '0;
            phase_d = PH_PAYLOAD;
          end
        end
        default: begin
          // finished: bytes are ignored until the next file start
        end
      endcase
    end
  end

endmodule

// ----- hdl/rmsws_back.sv -----
// ----------------------------------------------------------------------------
// rmsws_back
// Word packer: shifts payload bytes into big-endian words, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmsws_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rmsws_pkg::token_t     tok_i,
  input  rmsws_pkg::fifo_stat_t fifo_stat_i,
  output logic                  tok_pop_o,
  rmsws_out_if.source           out_o
);
  import rmsws_pkg::*;

  logic [23:0] asm_q, asm_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;
  logic        emit;

  // A word-ending byte needs a free output slot; other bytes always drain
  assign tok_pop_o = !fifo_stat_i.empty &&
                     (!tok_i.word_end || !out_valid_q || out_o.ready);
  assign emit      = tok_pop_o && tok_i.word_end;

  always_comb begin
    asm_d       = asm_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (tok_pop_o) begin
      asm_d = {asm_q[15:0], tok_i.data};
    end
    if (emit) begin
      out_data_d  = '{word_bits: {asm_q, tok_i.data}, component: tok_i.component,
                      last_word: tok_i.last_word};
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q      <= asm_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ----- hdl/record_marker_strip_word_swap_top.sv -----
// ----------------------------------------------------------------------------
// record_marker_strip_word_swap_top
// Deframes a record-marked particle file into tagged 32-bit coordinate words.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle, sustained, whenever the output keeps up: the
// parser handles every byte in the cycle it is accepted and hands payload bytes through
// a 4-entry queue to the word packer, so a stalled output only stops input
// once that queue fills. With the queue empty and the output register free, a
// word's last byte is written into the queue, then popped and registered with
// the word in the output register. A leading marker of 40 selects the header
// path (total from the header's first 8 bytes), otherwise the total comes
// from register 1; register 0 sets the payload bytes between marker pairs.
// Register writes are taken in any cycle (ready is always high) and should
// only be made while the block is idle. There is no start-up clearing pass.
`timescale 1ns / 1ps

module record_marker_strip_word_swap_top #(
  parameter int unsigned RECORD_COUNT_BITS = 31,
  parameter int unsigned TOTAL_BITS        = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmsws_in_if.sink    in_i,
  rmsws_out_if.source out_o,
  rmsws_cfg_if.sink   cfg_i
);
  import rmsws_pkg::*;

  logic [RECORD_COUNT_BITS-1:0] rec_bytes_q;
  logic [39:0]                  default_total_q;
  logic                         tok_push;
  logic                         tok_pop;
  token_t                       tok_in;
  token_t                       tok_out;
  fifo_stat_t                   fifo_stat;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_bytes_q     <= DEFAULT_RECORD_BYTES[RECORD_COUNT_BITS-1:0];
      default_total_q <= DEFAULT_TOTAL;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        CFG_REC_BYTES:     rec_bytes_q     <= cfg_i.wr_data[RECORD_COUNT_BITS-1:0];
        CFG_DEFAULT_TOTAL: default_total_q <= cfg_i.wr_data[39:0];
        default: begin
        end
      endcase
    end
  end

  rmsws_front #(
    .RECORD_COUNT_BITS (RECORD_COUNT_BITS),
    .TOTAL_BITS        (TOTAL_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .fifo_stat_i     (fifo_stat),
    .rec_bytes_i     (rec_bytes_q),
    .default_total_i (default_total_q),
    .tok_push_o      (tok_push),
    .tok_o           (tok_in)
  );

  rmsws_fifo #(
    .DEPTH (TOKEN_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tok_push),
    .push_data_i (tok_in),
    .pop_i       (tok_pop),
    .pop_data_o  (tok_out),
    .stat_o      (fifo_stat)
  );

  rmsws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_out),
    .fifo_stat_i (fifo_stat),
    .tok_pop_o   (tok_pop),
    .out_o       (out_o)
  );

  // Checks
`include "record_marker_strip_word_swap_top_assert.svh"

  `RMSWS_ASSERT_NOW(a_no_overflow, tok_push, !fifo_stat.full)
  `RMSWS_ASSERT_NOW(a_no_underflow, tok_pop, !fifo_stat.empty)
  `RMSWS_ASSERT_NOW(a_last_is_z, out_o.valid && out_o.data.last_word, out_o.data.component == 2'd2)
  `RMSWS_ASSERT_NEXT(a_word_lands, tok_pop && tok_out.word_end, out_o.valid)

endmodule
